// File: rtl/core/smtc_pkg.sv
`timescale 1ns / 1ps

package smtc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_HALF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_CYCLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRAY_ON     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONT_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INTER_LIMIT  = 3'd7;

  localparam logic [7:0]  RST_SHORT_PRESS = 8'd8;
  localparam logic [9:0]  RST_LONG_PRESS  = 10'd300;
  localparam logic [10:0] RST_LED_TIMEOUT = 11'd1000;
  localparam logic [7:0]  RST_TICKS_HALF  = 8'd50;
  localparam logic [7:0]  RST_HALF_CYCLE  = 8'd12;
  localparam logic [7:0]  RST_SPRAY_ON    = 8'd6;
  localparam logic [15:0] RST_CONT_LIMIT  = 16'd2400;
  localparam logic [15:0] RST_INTER_LIMIT = 16'd4800;

  localparam logic [9:0] PRESS_MAX = 10'h3FF;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_CONT  = 2'd1;
  localparam logic [1:0] MODE_INTER = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0]  short_press_ticks;
    logic [9:0]  long_press_ticks;
    logic [10:0] led_timeout_ticks;
    logic [7:0]  ticks_per_half_second;
    logic [7:0]  half_seconds_per_cycle;
    logic [7:0]  spray_on_half_seconds;
    logic [15:0] continuous_limit_cycles;
    logic [15:0] intermittent_limit_cycles;
  } cfg_t;

  typedef struct packed {
    logic [9:0] press_ticks;
    logic       long_reported;
  } key_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       asleep;
    logic       led_on;
    logic       spray_on;
  } result_t;

endpackage

// File: rtl/core/sprayer_mode_timer_controller.sv
`timescale 1ns / 1ps
// path: accepted input word -> input register -> output register -> out_tvalid
// throughput: one tick word per cycle while out_tready is high, set by the state update
// between the input register and the output register
// reset: synchronous active-low rst_n restores register defaults, clears all
// counters, mode off, spray off, led lit, awake; both stream sides empty

module sprayer_mode_timer_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [smtc_pkg::TDATA_W-1:0]      in_tdata,   // [0] key_pressed
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [smtc_pkg::TDATA_W-1:0]      out_tdata,  // [0] spray_on, [1] led_on,
                                                        // [2] asleep, [4:3] mode
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smtc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  smtc_pkg::cfg_t    cfg;
  smtc_pkg::result_t res_nxt;

  logic in_valid_r;
  logic key_r;
  logic out_valid_r;
  logic [smtc_pkg::TDATA_W-1:0] out_data_r;
  logic can_move;
  logic step;
  logic in_acc;

  assign can_move   = !out_valid_r || out_tready;
  assign step       = in_valid_r && can_move;
  assign in_tready  = !in_valid_r || can_move;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  smtc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smtc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .key     (key_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (can_move) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_tdata[0];
    end
    if (step) begin
      out_data_r <= {3'b000, res_nxt};
    end
  end

endmodule

// File: rtl/core/smtc_cfg_regs.sv
`timescale 1ns / 1ps

module smtc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smtc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output smtc_pkg::cfg_t                    cfg
);

  smtc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_ticks         <= smtc_pkg::RST_SHORT_PRESS;
      cfg_r.long_press_ticks          <= smtc_pkg::RST_LONG_PRESS;
      cfg_r.led_timeout_ticks         <= smtc_pkg::RST_LED_TIMEOUT;
      cfg_r.ticks_per_half_second     <= smtc_pkg::RST_TICKS_HALF;
      cfg_r.half_seconds_per_cycle    <= smtc_pkg::RST_HALF_CYCLE;
      cfg_r.spray_on_half_seconds     <= smtc_pkg::RST_SPRAY_ON;
      cfg_r.continuous_limit_cycles   <= smtc_pkg::RST_CONT_LIMIT;
      cfg_r.intermittent_limit_cycles <= smtc_pkg::RST_INTER_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        smtc_pkg::CFG_SHORT_PRESS: cfg_r.short_press_ticks         <= cfg_data[7:0];
        smtc_pkg::CFG_LONG_PRESS:  cfg_r.long_press_ticks          <= cfg_data[9:0];
        smtc_pkg::CFG_LED_TIMEOUT: cfg_r.led_timeout_ticks         <= cfg_data[10:0];
        smtc_pkg::CFG_TICKS_HALF:  cfg_r.ticks_per_half_second     <= cfg_data[7:0];
        smtc_pkg::CFG_HALF_CYCLE:  cfg_r.half_seconds_per_cycle    <= cfg_data[7:0];
        smtc_pkg::CFG_SPRAY_ON:    cfg_r.spray_on_half_seconds     <= cfg_data[7:0];
        smtc_pkg::CFG_CONT_LIMIT:  cfg_r.continuous_limit_cycles   <= cfg_data;
        smtc_pkg::CFG_INTER_LIMIT: cfg_r.intermittent_limit_cycles <= cfg_data;
      endcase
    end
  end

endmodule

// File: rtl/core/smtc_key_qual.sv
`timescale 1ns / 1ps

module smtc_key_qual (
  input  logic                   key,
  input  smtc_pkg::key_state_t   ks,
  input  logic [7:0]             short_press_ticks,
  input  logic [9:0]             long_press_ticks,
  output smtc_pkg::key_state_t   ks_nxt,
  output logic [1:0]             ev
);

  logic [9:0] press_inc;

  always_comb begin
    press_inc = (ks.press_ticks != smtc_pkg::PRESS_MAX) ? ks.press_ticks + 10'd1
                                                        : ks.press_ticks;
    ks_nxt = ks;
    ev     = smtc_pkg::EV_NONE;
    if (key) begin
      ks_nxt.press_ticks = press_inc;
      if (press_inc >= long_press_ticks) begin
        ks_nxt.press_ticks = long_press_ticks;
        if (!ks.long_reported) begin
          ks_nxt.long_reported = 1'b1;
          ev                   = smtc_pkg::EV_LONG;
        end
      end
    end else begin
      if (ks.press_ticks < long_press_ticks &&
          ks.press_ticks >= {2'b00, short_press_ticks}) begin
        ev = smtc_pkg::EV_SHORT;
      end
      ks_nxt.press_ticks   = 10'd0;
      ks_nxt.long_reported = 1'b0;
    end
  end

endmodule

// File: rtl/core/smtc_core.sv
`timescale 1ns / 1ps

module smtc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               key,
  input  smtc_pkg::cfg_t     cfg,
  output smtc_pkg::result_t  res_nxt
);

  smtc_pkg::key_state_t ks_r, ks_nxt, ks_q;
  logic [1:0]  ev;
  logic [1:0]  mode_r, mode_nxt;
  logic        led_hold_r, led_hold_nxt;
  logic [11:0] led_timer_r, led_timer_nxt;
  logic [7:0]  tick_count_r, tick_count_nxt;
  logic [7:0]  half_count_r, half_count_nxt;
  logic [15:0] session_r, session_nxt;
  logic        spray_r, spray_nxt;
  logic        led_r, led_nxt;
  logic        sleep_r, sleep_nxt;

  logic [11:0] timeout_ext;
  logic [11:0] timeout_park;
  logic [15:0] limit;

  smtc_key_qual u_key_qual (
    .key               (key),
    .ks                (ks_r),
    .short_press_ticks (cfg.short_press_ticks),
    .long_press_ticks  (cfg.long_press_ticks),
    .ks_nxt            (ks_q),
    .ev                (ev)
  );

  always_comb begin
    timeout_ext    = {1'b0, cfg.led_timeout_ticks};
    timeout_park   = timeout_ext + 12'd1;
    limit          = 16'd0;
    ks_nxt         = ks_r;
    mode_nxt       = mode_r;
    led_hold_nxt   = led_hold_r;
    led_timer_nxt  = led_timer_r;
    tick_count_nxt = tick_count_r;
    half_count_nxt = half_count_r;
    session_nxt    = session_r;
    spray_nxt      = spray_r;
    led_nxt        = led_r;
    sleep_nxt      = sleep_r;

    if (sleep_r) begin
      if (key) begin
        sleep_nxt = 1'b0;
      end
    end else begin
      // led stage
      led_timer_nxt = led_timer_r + 12'd1;
      if (led_timer_nxt >= timeout_ext) begin
        if (!led_hold_r) begin
          led_nxt = 1'b0;
        end
        led_timer_nxt = timeout_park;
      end
      if (led_hold_r) begin
        led_nxt = 1'b1;
      end
      if (mode_r == smtc_pkg::MODE_INTER) begin
        spray_nxt = (half_count_r < cfg.spray_on_half_seconds);
      end

      // key stage
      ks_nxt = ks_q;
      unique case (ev)
        smtc_pkg::EV_SHORT: begin
          session_nxt = 16'd0;
          unique case (mode_r)
            smtc_pkg::MODE_OFF:  mode_nxt = smtc_pkg::MODE_CONT;
            smtc_pkg::MODE_CONT: mode_nxt = smtc_pkg::MODE_INTER;
            default:             mode_nxt = smtc_pkg::MODE_OFF;
          endcase
          if (mode_nxt == smtc_pkg::MODE_CONT) begin
            spray_nxt = 1'b1;
          end else if (mode_nxt == smtc_pkg::MODE_OFF) begin
            spray_nxt = 1'b0;
          end
        end
        smtc_pkg::EV_LONG: begin
          if (led_hold_r) begin
            led_hold_nxt  = 1'b0;
            led_timer_nxt = timeout_park;
          end else begin
            led_hold_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // timer stage
      tick_count_nxt = tick_count_r + 8'd1;
      if (tick_count_nxt >= cfg.ticks_per_half_second) begin
        tick_count_nxt = 8'd0;
        half_count_nxt = half_count_r + 8'd1;
        if (half_count_nxt >= cfg.half_seconds_per_cycle) begin
          limit = (mode_nxt == smtc_pkg::MODE_INTER) ? cfg.intermittent_limit_cycles
                                                     : cfg.continuous_limit_cycles;
          half_count_nxt = 8'd0;
          session_nxt    = session_nxt + 16'd1;
          if (session_nxt >= limit ||
              (mode_nxt == smtc_pkg::MODE_OFF && led_timer_nxt >= timeout_ext &&
               !led_hold_nxt)) begin
            session_nxt = 16'd0;
            mode_nxt    = smtc_pkg::MODE_OFF;
            spray_nxt   = 1'b0;
            led_nxt     = 1'b0;
            sleep_nxt   = 1'b1;
          end
        end
      end
    end

    res_nxt.mode     = mode_nxt;
    res_nxt.asleep   = sleep_nxt;
    res_nxt.led_on   = led_nxt;
    res_nxt.spray_on = spray_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r         <= '0;
      mode_r       <= smtc_pkg::MODE_OFF;
      led_hold_r   <= 1'b0;
      led_timer_r  <= 12'd0;
      tick_count_r <= 8'd0;
      half_count_r <= 8'd0;
      session_r    <= 16'd0;
      spray_r      <= 1'b0;
      led_r        <= 1'b1;
      sleep_r      <= 1'b0;
    end else if (step) begin
      ks_r         <= ks_nxt;
      mode_r       <= mode_nxt;
      led_hold_r   <= led_hold_nxt;
      led_timer_r  <= led_timer_nxt;
      tick_count_r <= tick_count_nxt;
      half_count_r <= half_count_nxt;
      session_r    <= session_nxt;
      spray_r      <= spray_nxt;
      led_r        <= led_nxt;
      sleep_r      <= sleep_nxt;
    end
  end

endmodule

// File: rtl/core/smtc_checker.sv
`timescale 1ns / 1ps

module smtc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [smtc_pkg::TDATA_W-1:0]  out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // empty output side never blocks the input side
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // sleeping means everything dark and mode off
  a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == 2'b00 && out_tdata[4:3] == 2'b00)
    else $error("asleep with spray, led or mode active");

  // off mode never sprays, continuous mode always sprays
  a_mode_spray: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4:3] == 2'b00 || out_tdata[4:3] == 2'b01)
    |-> out_tdata[0] == out_tdata[3])
    else $error("spray disagrees with mode");

endmodule

bind sprayer_mode_timer_controller smtc_checker u_smtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: bench/sprayer_mode_timer_controller_test.sv
`timescale 1ns / 1ps

module sprayer_mode_timer_controller_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BOOT_ROWS = 3;
  localparam int DIRECTED_N = 28;
  localparam int EXTREME_ITEMS = 25;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 35;
  localparam int SATURATE_HOLD = 1030;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {EXT_MIN, EXT_ZERO, EXT_MAX} extreme_t;

  typedef struct packed {
    logic              typed;
    logic              key;
    smtc_pkg::result_t want;
  } stim_row_t;

  localparam smtc_pkg::result_t AWAKE_OFF = {smtc_pkg::MODE_OFF, 1'b0, 1'b1, 1'b0};
  localparam smtc_pkg::result_t UNTYPED   = '0;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [smtc_pkg::TDATA_W-1:0]    in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [smtc_pkg::TDATA_W-1:0]    out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [smtc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [smtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sprayer_mode_timer_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [0] key_pressed
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [0] spray_on, [1] led_on, [2] asleep, [4:3] mode
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted register file
  logic [7:0]  short_thr, ticks_half, halves_cycle, spray_halves;
  logic [9:0]  long_thr;
  logic [10:0] led_thr;
  logic [15:0] cont_cap, inter_cap;

  // predicted controller state
  logic [9:0]  hold_ticks;
  logic        long_seen, hold_led, spraying, lit, sleeping;
  logic [1:0]  cur_mode;
  logic [11:0] led_age;
  logic [7:0]  tick_cnt, half_cnt;
  logic [15:0] cycle_cnt;

  logic [15:0]       reg_plan [8];
  smtc_pkg::result_t expected_q [$];
  smtc_pkg::result_t mon_got, mon_want;
  stim_row_t         directed_rows [DIRECTED_N];
  int                send_gap_pct = 0;
  int                stall_pct = 0;
  int                sent_items = 0;
  int                quiet_cycles = 0;
  logic              failed = 1'b0;

  task automatic reset_prediction();
    short_thr    = smtc_pkg::RST_SHORT_PRESS;
    long_thr     = smtc_pkg::RST_LONG_PRESS;
    led_thr      = smtc_pkg::RST_LED_TIMEOUT;
    ticks_half   = smtc_pkg::RST_TICKS_HALF;
    halves_cycle = smtc_pkg::RST_HALF_CYCLE;
    spray_halves = smtc_pkg::RST_SPRAY_ON;
    cont_cap     = smtc_pkg::RST_CONT_LIMIT;
    inter_cap    = smtc_pkg::RST_INTER_LIMIT;
    hold_ticks   = '0;
    long_seen    = 1'b0;
    cur_mode     = smtc_pkg::MODE_OFF;
    hold_led     = 1'b0;
    led_age      = '0;
    tick_cnt     = '0;
    half_cnt     = '0;
    cycle_cnt    = '0;
    spraying     = 1'b0;
    lit          = 1'b1;
    sleeping     = 1'b0;
  endtask

  function automatic smtc_pkg::result_t next_tick_result(input logic key);
    logic [1:0]  ev;
    logic [15:0] cap;
    if (sleeping) begin
      if (key) sleeping = 1'b0;
    end else begin
      // led timer
      led_age = led_age + 12'd1;
      if (led_age >= {1'b0, led_thr}) begin
        if (!hold_led) lit = 1'b0;
        led_age = {1'b0, led_thr} + 12'd1;
      end
      if (hold_led) lit = 1'b1;
      if (cur_mode == smtc_pkg::MODE_INTER) spraying = half_cnt < spray_halves;

      // key qualification
      ev = smtc_pkg::EV_NONE;
      if (key) begin
        if (hold_ticks < smtc_pkg::PRESS_MAX) hold_ticks = hold_ticks + 10'd1;
        if (hold_ticks >= long_thr) begin
          hold_ticks = long_thr;
          if (!long_seen) begin
            long_seen = 1'b1;
            ev = smtc_pkg::EV_LONG;
          end
        end
      end else begin
        if (hold_ticks < long_thr && hold_ticks >= {2'b0, short_thr}) ev = smtc_pkg::EV_SHORT;
        hold_ticks = '0;
        long_seen = 1'b0;
      end

      if (ev == smtc_pkg::EV_SHORT) begin
        cycle_cnt = '0;
        cur_mode = (cur_mode == smtc_pkg::MODE_INTER) ? smtc_pkg::MODE_OFF
                                                      : cur_mode + 2'd1;
        if (cur_mode == smtc_pkg::MODE_CONT) spraying = 1'b1;
        else if (cur_mode == smtc_pkg::MODE_OFF) spraying = 1'b0;
      end else if (ev == smtc_pkg::EV_LONG) begin
        if (hold_led) begin
          hold_led = 1'b0;
          led_age = {1'b0, led_thr} + 12'd1;
        end else begin
          hold_led = 1'b1;
        end
      end

      // half-second and cycle counters
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= ticks_half) begin
        tick_cnt = '0;
        half_cnt = half_cnt + 8'd1;
        if (half_cnt >= halves_cycle) begin
          cap = (cur_mode == smtc_pkg::MODE_INTER) ? inter_cap : cont_cap;
          half_cnt = '0;
          cycle_cnt = cycle_cnt + 16'd1;
          if (cycle_cnt >= cap ||
              (cur_mode == smtc_pkg::MODE_OFF && led_age >= {1'b0, led_thr} &&
               !hold_led)) begin
            cycle_cnt = '0;
            cur_mode = smtc_pkg::MODE_OFF;
            spraying = 1'b0;
            lit = 1'b0;
            sleeping = 1'b1;
          end
        end
      end
    end
    return {cur_mode, sleeping, lit, spraying};
  endfunction

  function automatic logic [15:0] pick_reg(input int usual_hi, input int full_hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'd0;
    if (roll < 10) return 16'(full_hi);
    if (roll < 20) return 16'($urandom_range(0, full_hi));
    return 16'($urandom_range(1, usual_hi));
  endfunction

  task automatic set_idling(input int phase);
    case (idle_mode_t'(phase % 4))
      IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 61; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 61; end
      default:       begin send_gap_pct = 15; stall_pct = 15; end
    endcase
  endtask

  task automatic program_regs();
    int                             base;
    logic [smtc_pkg::CFG_IDX_W-1:0] idx;
    base = $urandom_range(0, 7);
    for (int j = 0; j < 8; j++) begin
      idx = smtc_pkg::CFG_IDX_W'(base + j);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= reg_plan[idx];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        smtc_pkg::CFG_SHORT_PRESS: short_thr    = reg_plan[idx][7:0];
        smtc_pkg::CFG_LONG_PRESS:  long_thr     = reg_plan[idx][9:0];
        smtc_pkg::CFG_LED_TIMEOUT: led_thr      = reg_plan[idx][10:0];
        smtc_pkg::CFG_TICKS_HALF:  ticks_half   = reg_plan[idx][7:0];
        smtc_pkg::CFG_HALF_CYCLE:  halves_cycle = reg_plan[idx][7:0];
        smtc_pkg::CFG_SPRAY_ON:    spray_halves = reg_plan[idx][7:0];
        smtc_pkg::CFG_CONT_LIMIT:  cont_cap     = reg_plan[idx];
        default:                   inter_cap    = reg_plan[idx];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic key, input logic typed,
                           input smtc_pkg::result_t typed_want);
    smtc_pkg::result_t want;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(smtc_pkg::TDATA_W-1){1'b0}}, key};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    want = next_tick_result(key);
    expected_q.push_back(typed ? typed_want : want);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_burst();
    int pick;
    int len;
    // sender holds off until every result is back
    if ($urandom_range(0, 39) == 0) drain_results();
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      case ($urandom_range(0, 5))
        0:       len = int'(short_thr) - 1;
        1:       len = int'(short_thr);
        2:       len = $urandom_range(int'(short_thr), int'(long_thr));
        3:       len = int'(long_thr) - 1;
        4:       len = int'(long_thr);
        default: len = int'(long_thr) + $urandom_range(1, 5);
      endcase
      if (len > 64) len = $urandom_range(1, 64);
      if (len < 1) len = 1;
      repeat (len) send_tick(1'b1, 1'b0, UNTYPED);
      repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'b0, UNTYPED);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), 1'b0, UNTYPED);
    end else begin
      // quiet stretch so the timers run into sleep
      repeat ($urandom_range(5, 40)) send_tick(1'b0, 1'b0, UNTYPED);
    end
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = out_tdata[4:0];
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected, ", $time,
                 "got spray %0b led %0b asleep %0b mode %0d",
                 mon_got.spray_on, mon_got.led_on, mon_got.asleep, mon_got.mode);
        failed = 1'b1;
      end else begin
        mon_want = expected_q.pop_front();
        if (mon_got !== mon_want) begin
          $display("%0t: expected spray %0b led %0b asleep %0b mode %0d",
                   $time, mon_want.spray_on, mon_want.led_on, mon_want.asleep,
                   mon_want.mode,
                   ", got spray %0b led %0b asleep %0b mode %0d",
                   mon_got.spray_on, mon_got.led_on, mon_got.asleep, mon_got.mode);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sprayer_mode_timer_controller_test NOT OK");
      $finish;
    end
  end

  initial begin
    int start;
    directed_rows = '{
      // reset values: short ticks and releases leave everything at rest
      {1'b1, 1'b0, AWAKE_OFF},
      {1'b1, 1'b1, AWAKE_OFF},
      {1'b1, 1'b0, AWAKE_OFF},
      // short press to continuous, then to intermittent
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b0, UNTYPED},
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b0, UNTYPED},
      {1'b0, 1'b0, UNTYPED},
      // long press sets the led hold, a second one clears it
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED},
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b0, UNTYPED},
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED},
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b0, UNTYPED},
      // short press back to off, idle into sleep, ignored ticks, wake tick
      {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b1, UNTYPED}, {1'b0, 1'b0, UNTYPED},
      {1'b0, 1'b0, UNTYPED}, {1'b0, 1'b0, UNTYPED}, {1'b0, 1'b0, UNTYPED},
      {1'b0, 1'b0, UNTYPED},
      {1'b0, 1'b1, UNTYPED}
    };
    reset_prediction();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_NONE);
    for (int i = 0; i < DIRECTED_N; i++) begin
      if (i == BOOT_ROWS) begin
        drain_results();
        reg_plan[smtc_pkg::CFG_SHORT_PRESS] = 16'd2;
        reg_plan[smtc_pkg::CFG_LONG_PRESS]  = 16'd4;
        reg_plan[smtc_pkg::CFG_LED_TIMEOUT] = 16'd10;
        reg_plan[smtc_pkg::CFG_TICKS_HALF]  = 16'd1;
        reg_plan[smtc_pkg::CFG_HALF_CYCLE]  = 16'd3;
        reg_plan[smtc_pkg::CFG_SPRAY_ON]    = 16'd1;
        reg_plan[smtc_pkg::CFG_CONT_LIMIT]  = 16'd20;
        reg_plan[smtc_pkg::CFG_INTER_LIMIT] = 16'd20;
        program_regs();
      end
      send_tick(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // register extremes: all minimum, all zero, all maximum
    for (int e = 0; e < 3; e++) begin
      set_idling(e);
      case (extreme_t'(e))
        EXT_MIN: begin
          foreach (reg_plan[r]) reg_plan[r] = 16'd1;
          reg_plan[smtc_pkg::CFG_SPRAY_ON] = 16'd0;
        end
        EXT_ZERO: foreach (reg_plan[r]) reg_plan[r] = 16'd0;
        default: begin
          reg_plan[smtc_pkg::CFG_SHORT_PRESS] = 16'd255;
          reg_plan[smtc_pkg::CFG_LONG_PRESS]  = 16'd1023;
          reg_plan[smtc_pkg::CFG_LED_TIMEOUT] = 16'd2047;
          reg_plan[smtc_pkg::CFG_TICKS_HALF]  = 16'd255;
          reg_plan[smtc_pkg::CFG_HALF_CYCLE]  = 16'd255;
          reg_plan[smtc_pkg::CFG_SPRAY_ON]    = 16'd255;
          reg_plan[smtc_pkg::CFG_CONT_LIMIT]  = 16'hFFFF;
          reg_plan[smtc_pkg::CFG_INTER_LIMIT] = 16'hFFFF;
        end
      endcase
      program_regs();
      // long hold past the press counter ceiling
      if (extreme_t'(e) == EXT_MAX) repeat (SATURATE_HOLD) send_tick(1'b1, 1'b0, UNTYPED);
      start = sent_items;
      while (sent_items - start < EXTREME_ITEMS) random_burst();
      drain_results();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idling(p);
      reg_plan[smtc_pkg::CFG_SHORT_PRESS] = pick_reg(5, 255);
      reg_plan[smtc_pkg::CFG_LONG_PRESS]  = pick_reg(20, 1023);
      reg_plan[smtc_pkg::CFG_LED_TIMEOUT] = pick_reg(40, 2047);
      reg_plan[smtc_pkg::CFG_TICKS_HALF]  = pick_reg(3, 255);
      reg_plan[smtc_pkg::CFG_HALF_CYCLE]  = pick_reg(5, 255);
      reg_plan[smtc_pkg::CFG_SPRAY_ON]    = pick_reg(5, 255);
      reg_plan[smtc_pkg::CFG_CONT_LIMIT]  = pick_reg(8, 65535);
      reg_plan[smtc_pkg::CFG_INTER_LIMIT] = pick_reg(8, 65535);
      program_regs();
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) random_burst();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (failed)
      $display("sprayer_mode_timer_controller_test NOT OK");
    else
      $display("sprayer_mode_timer_controller_test OK");
    $finish;
  end

endmodule
